@@ hdl/bfv_pkg.sv @@
package bfv_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned POS_W  = 17;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SYNC_FIRST     = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND    = 2'd1;
    localparam logic [1:0] REG_MSG_CLASS      = 2'd2;
    localparam logic [1:0] REG_EXPECTED_IDENT = 2'd3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;

    localparam logic [POS_W-1:0] POS_MAX          = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] HEADER_SUM_OFFSET = 17'd4;
    localparam logic [POS_W-1:0] MIN_FRAME_LAST   = 17'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] msg_class;
        logic [BYTE_W-1:0] expected_ident;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_buffer;
    } t_item;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] sum_a;
        logic [BYTE_W-1:0] sum_b;
        logic [LEN_W-1:0]  length;
    } t_result;

endpackage

@@ hdl/binary_frame_validator_top.sv @@
// Frame validator with an 8-bit Fletcher checksum. The block takes a received
// buffer one byte per item, with end_of_buffer set on the last byte, and gives
// exactly one result for each buffer when its last byte has been processed.
// Bytes 0 and 1 must match the two sync registers, bytes 2 and 3 the expected
// class and ident, and bytes 4 and 5 carry a little-endian payload length L.
// The sums are kept over positions 2 through L+5 and compared against the
// final two bytes of the buffer. Buffers shorter than eight bytes, and buffers
// that end before the summed range is complete, report status 1 (invalid).
// The block accepts one byte in every clock cycle while no last byte waits. A
// result goes from the input register through the combinational checksum
// update into the result register, and is shown on the outputs from there.
// A last byte waits in the input register only while an earlier result is
// still untaken, and then the input stalls while the result waits; other
// bytes never wait. Configuration registers are written through a plain
// write port and should only be changed while no buffer is in progress.
module binary_frame_validator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [7:0]  o_sum_a_out,
    output logic [7:0]  o_sum_b_out,
    output logic [15:0] o_length_out
);
    import bfv_pkg::*;

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_result;
    logic    r_out_valid;
    t_result core_result;
    logic    out_free;
    logic    advance;

    // Configuration registers, reset to the standard sync pattern with class and ident zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= SYNC_FIRST_RST;
            r_cfg.sync_second    <= SYNC_SECOND_RST;
            r_cfg.msg_class      <= '0;
            r_cfg.expected_ident <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SYNC_FIRST:     r_cfg.sync_first     <= i_cfg_data;
                REG_SYNC_SECOND:    r_cfg.sync_second    <= i_cfg_data;
                REG_MSG_CLASS:      r_cfg.msg_class      <= i_cfg_data;
                REG_EXPECTED_IDENT: r_cfg.expected_ident <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // A byte in the input register moves through the checksum logic unless it
    // is a last byte and the result register still holds an untaken result.
    // Bytes that give no result never wait.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_item.end_of_buffer || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.data_byte     <= i_data_byte;
            r_item.end_of_buffer <= i_end_of_buffer;
        end
    end

    bfv_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_advance(advance),
        .o_result (core_result)
    );

    // Result register: loaded when a last byte passes through the core.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_item.end_of_buffer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_item.end_of_buffer) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_result.status;
    assign o_sum_a_out  = r_result.sum_a;
    assign o_sum_b_out  = r_result.sum_b;
    assign o_length_out = r_result.length;

endmodule

@@ hdl/bfv_core.sv @@
module bfv_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bfv_pkg::t_cfg    i_cfg,
    input  bfv_pkg::t_item   i_item,
    input  logic             i_advance,
    output bfv_pkg::t_result o_result
);
    import bfv_pkg::*;

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [BYTE_W-1:0] r_sum_a,  n_sum_a;
    logic [BYTE_W-1:0] r_sum_b,  n_sum_b;
    logic              r_hdr_ok, n_hdr_ok;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [BYTE_W-1:0] r_prev,   n_prev;

    logic [BYTE_W-1:0] b;
    logic              hdr_bad;
    logic [POS_W-1:0]  range_end;
    logic              in_range;

    assign b = i_item.data_byte;

    always_comb begin
        hdr_bad = ((r_pos == 17'd0) && (b != i_cfg.sync_first))
               || ((r_pos == 17'd1) && (b != i_cfg.sync_second))
               || ((r_pos == 17'd2) && (b != i_cfg.msg_class))
               || ((r_pos == 17'd3) && (b != i_cfg.expected_ident));
        n_hdr_ok = r_hdr_ok && !hdr_bad;

        n_len = r_len;
        if (r_pos == 17'd4) begin
            n_len = {r_len[LEN_W-1:BYTE_W], b};
        end else if (r_pos == 17'd5) begin
            n_len = {b, r_len[BYTE_W-1:0]};
        end

        // The summed range runs from position two to length plus five.
        range_end = {1'b0, n_len} + HEADER_SUM_OFFSET + 17'd1;
        in_range  = (r_pos >= 17'd2) && (r_pos <= range_end);

        n_sum_a = in_range ? r_sum_a + b : r_sum_a;
        n_sum_b = in_range ? r_sum_b + n_sum_a : r_sum_b;

        n_pos  = (r_pos != POS_MAX) ? r_pos + 17'd1 : r_pos;
        n_prev = b;

        o_result.status = !(n_hdr_ok
                            && (r_pos >= MIN_FRAME_LAST)
                            && (r_pos >= range_end)
                            && (n_sum_a == r_prev)
                            && (n_sum_b == b));
        o_result.sum_a  = n_sum_a;
        o_result.sum_b  = n_sum_b;
        o_result.length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.end_of_buffer)) begin
            r_pos    <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_hdr_ok <= 1'b1;
            r_len    <= '0;
            r_prev   <= '0;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_hdr_ok <= n_hdr_ok;
            r_len    <= n_len;
            r_prev   <= n_prev;
        end
    end

endmodule

@@ hdl/bfv_checker.sv @@
module bfv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_end_of_buffer,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic [7:0]  o_sum_a_out,
    input logic [7:0]  o_sum_b_out,
    input logic [15:0] o_length_out
);

    // A pending result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_status) && $stable(o_sum_a_out)
            && $stable(o_sum_b_out) && $stable(o_length_out))
        else $error("result changed while stalled");

    // With no result pending, nothing can hold up the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

    // A new result only follows an accepted last byte, which passes the input register first.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_end_of_buffer, 2))
        else $error("result without a last byte");

endmodule

bind binary_frame_validator_top bfv_checker u_bfv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_end_of_buffer(i_end_of_buffer),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_sum_a_out    (o_sum_a_out),
    .o_sum_b_out    (o_sum_b_out),
    .o_length_out   (o_length_out)
);

@@ test/binary_frame_validator_top_test.sv @@
// Testbench for the Fletcher-8 frame validator.
//
// A directed table comes first. Then four random phases run, each under its own register
// setting. Every accepted byte goes into a cycle-free model of the validator. That model
// queues one expected verdict for each buffer, and a checker compares every accepted
// result against the oldest verdict.
module binary_frame_validator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfv_pkg::*;

    // No handshake may stay quiet for this many cycles in a healthy run. The longest
    // deliberate pause is the short settle time before a register write or at the end.
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_BYTES   = 375;
    localparam int          DIRECTED_ROWS = 24;

    // One row of the directed table. When has_res is set on a final byte, the typed
    // verdict replaces the predicted one.
    typedef struct packed {
        t_item   item;
        logic    has_res;
        t_result res;
    } t_stim_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = REG_SYNC_FIRST;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        eob       = 1'b0;
    logic        out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_status;
    logic [7:0]  o_sum_a_out;
    logic [7:0]  o_sum_b_out;
    logic [15:0] o_length_out;

    // Idle and stall rates, in percent, for the byte sender and the result receiver.
    int unsigned in_idle_pct   = 23;
    int unsigned out_stall_pct = 23;

    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned phase_bytes  = 0;

    // Shadow of the configuration registers and of the per-buffer state of the validator.
    t_cfg             cfg_shadow = '{SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'h00};
    logic [POS_W-1:0] frame_pos  = '0;
    logic [7:0]       fl_sum_a   = 8'h00;
    logic [7:0]       fl_sum_b   = 8'h00;
    logic             hdr_match  = 1'b1;
    logic [15:0]      pay_len    = 16'h0000;
    logic [7:0]       prev_byte  = 8'h00;

    t_result frame_verdicts[$];
    t_result want_verdict;
    logic [7:0] frame_buf[$];

    // Directed buffers, all under the reset register values.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // A lone byte that matches neither sync value. The buffer is short and the header
        // is wrong, and no byte has been summed yet.
        '{'{8'hFF, 1'b1}, 1'b1, '{1'b1, 8'h00, 8'h00, 16'h0000}},
        // The smallest valid frame: empty payload, all-zero header tail, zero checksum.
        '{'{SYNC_FIRST_RST, 1'b0}, 1'b0, '0},
        '{'{SYNC_SECOND_RST, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b1, '{1'b0, 8'h00, 8'h00, 16'h0000}},
        // The largest length, 0xFFFF, in a buffer that ends long before the summed range
        // is complete.
        '{'{SYNC_FIRST_RST, 1'b0}, 1'b0, '0},
        '{'{SYNC_SECOND_RST, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b1}, 1'b0, '0},
        // Length 2 in an 8-byte buffer. Both checksum bytes fall inside the summed range,
        // and these two values still make the frame check out.
        '{'{SYNC_FIRST_RST, 1'b0}, 1'b0, '0},
        '{'{SYNC_SECOND_RST, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h02, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h7C, 1'b0}, 1'b0, '0},
        '{'{8'hFE, 1'b1}, 1'b0, '0}
    };

    binary_frame_validator_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (data_byte),
        .i_end_of_buffer (eob),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_status        (o_status),
        .o_sum_a_out     (o_sum_a_out),
        .o_sum_b_out     (o_sum_b_out),
        .o_length_out    (o_length_out)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the validator model by one accepted byte. On the final byte of a buffer,
    // it queues the verdict and clears the per-buffer state.
    function automatic void track_byte(input logic [7:0] b, input logic last);
        logic [POS_W-1:0] range_end;
        t_result          verdict;
        if (frame_pos == 0 && b != cfg_shadow.sync_first) hdr_match = 1'b0;
        if (frame_pos == 1 && b != cfg_shadow.sync_second) hdr_match = 1'b0;
        if (frame_pos == 2 && b != cfg_shadow.msg_class) hdr_match = 1'b0;
        if (frame_pos == 3 && b != cfg_shadow.expected_ident) hdr_match = 1'b0;
        if (frame_pos == 4) pay_len[7:0] = b;
        if (frame_pos == 5) pay_len[15:8] = b;

        // The summed range ends at position L+5. At 17 bits this never wraps, even when
        // the length is 0xFFFF.
        range_end = POS_W'(pay_len) + HEADER_SUM_OFFSET + POS_W'(1);
        if (frame_pos >= 2 && frame_pos <= range_end) begin
            fl_sum_a = fl_sum_a + b;
            fl_sum_b = fl_sum_b + fl_sum_a;
        end

        if (!last) begin
            prev_byte = b;
            if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
        end else begin
            verdict.status = !(hdr_match && frame_pos >= MIN_FRAME_LAST
                               && frame_pos >= range_end
                               && fl_sum_a == prev_byte && fl_sum_b == b);
            verdict.sum_a  = fl_sum_a;
            verdict.sum_b  = fl_sum_b;
            verdict.length = pay_len;
            frame_verdicts.push_back(verdict);
            frame_pos = '0;
            fl_sum_a  = 8'h00;
            fl_sum_b  = 8'h00;
            hdr_match = 1'b1;
            pay_len   = 16'h0000;
            prev_byte = 8'h00;
        end
    endfunction

    // Presents one item after an optional random gap and holds it until it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        eob       <= last;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        track_byte(b, last);
        phase_bytes++;
    endtask

    task automatic send_buffer();
        foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // Builds a well-formed frame for the current registers: the header, a random payload
    // of pay_bytes bytes, pad_bytes random bytes past the summed range, and then the
    // correct Fletcher pair.
    function automatic void build_frame(input int pay_bytes, input int pad_bytes);
        logic [7:0] ca;
        logic [7:0] cb;
        frame_buf.delete();
        frame_buf.push_back(cfg_shadow.sync_first);
        frame_buf.push_back(cfg_shadow.sync_second);
        frame_buf.push_back(cfg_shadow.msg_class);
        frame_buf.push_back(cfg_shadow.expected_ident);
        frame_buf.push_back(pay_bytes[7:0]);
        frame_buf.push_back(pay_bytes[15:8]);
        repeat (pay_bytes + pad_bytes) frame_buf.push_back(8'($urandom));
        ca = 8'h00;
        cb = 8'h00;
        for (int k = 2; k <= pay_bytes + 5; k++) begin
            ca = ca + frame_buf[k];
            cb = cb + ca;
        end
        frame_buf.push_back(ca);
        frame_buf.push_back(cb);
    endfunction

    // Sends one random buffer. Most buffers are good frames. The rest are damaged in one
    // of several ways, or are plain noise.
    task automatic send_random_buffer();
        int kind;
        int pay;
        int cut;
        int pos;
        kind = $urandom_range(99);
        pay  = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(16);
        build_frame(pay, 0);
        if (kind < 55) begin
            // Leave the frame intact.
        end else if (kind < 67) begin
            // Flip bits in one byte. Hits on the high length byte also produce huge lengths.
            pos = $urandom_range(frame_buf.size() - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(255, 1));
        end else if (kind < 77) begin
            // Cut the frame short. Often this also leaves it under eight bytes.
            cut = $urandom_range(frame_buf.size() - 1, 1);
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
        end else if (kind < 85) begin
            // Append trailing bytes, so the checksum is no longer at the end.
            repeat ($urandom_range(4, 1)) frame_buf.push_back(8'($urandom));
        end else if (kind < 90) begin
            // Drop one or two bytes, so one or both of the last two bytes fall inside the summed range.
            repeat ($urandom_range(2, 1)) void'(frame_buf.pop_back());
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(12, 1)) frame_buf.push_back(8'($urandom));
        end
        send_buffer();
    endtask

    // Stops the byte stream and waits until every queued verdict has been checked. A short
    // settle time follows, for a result that may still be in the pipeline.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_SYNC_FIRST:     cfg_shadow.sync_first     = val;
            REG_SYNC_SECOND:    cfg_shadow.sync_second    = val;
            REG_MSG_CLASS:      cfg_shadow.msg_class      = val;
            REG_EXPECTED_IDENT: cfg_shadow.expected_ident = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input t_cfg c);
        drain();
        write_reg(REG_SYNC_FIRST, c.sync_first);
        write_reg(REG_SYNC_SECOND, c.sync_second);
        write_reg(REG_MSG_CLASS, c.msg_class);
        write_reg(REG_EXPECTED_IDENT, c.expected_ident);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // The result receiver stalls at random. The stall rate drops to zero in the phase that
    // runs with no idling.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Checks each accepted result, field by field, against the oldest queued verdict.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (frame_verdicts.size() == 0) begin
                $error("result with no buffer pending: status %0d sum_a %0h sum_b %0h length %0h",
                       o_status, o_sum_a_out, o_sum_b_out, o_length_out);
                fail_count++;
            end else begin
                want_verdict = frame_verdicts.pop_front();
                if (o_status !== want_verdict.status) begin
                    $error("status: expected %0d, got %0d", want_verdict.status, o_status);
                    fail_count++;
                end
                if (o_sum_a_out !== want_verdict.sum_a) begin
                    $error("sum_a_out: expected %0h, got %0h", want_verdict.sum_a, o_sum_a_out);
                    fail_count++;
                end
                if (o_sum_b_out !== want_verdict.sum_b) begin
                    $error("sum_b_out: expected %0h, got %0h", want_verdict.sum_b, o_sum_b_out);
                    fail_count++;
                end
                if (o_length_out !== want_verdict.length) begin
                    $error("length_out: expected %0h, got %0h", want_verdict.length,
                           o_length_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a run in which no handshake completes for a long time has hung.
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAIL binary_frame_validator_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cfg phase_cfg;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].item.data_byte, directed_rows[r].item.end_of_buffer);
            if (directed_rows[r].has_res) frame_verdicts[$] = directed_rows[r].res;
        end

        // Phases: all registers zero, all registers 0xFF with no idling on either side,
        // back to the reset values, and then random values.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       phase_cfg = '{8'h00, 8'h00, 8'h00, 8'h00};
                1:       phase_cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                2:       phase_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'h00};
                default: phase_cfg = '{8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom)};
            endcase
            apply_config(phase_cfg);
            in_idle_pct   = (ph == 1) ? 0 : 23;
            out_stall_pct = (ph == 1) ? 0 : 23;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) send_random_buffer();
        end

        drain();
        if (fail_count == 0) begin
            $display("PASS binary_frame_validator_top");
        end else begin
            $display("FAIL binary_frame_validator_top");
        end
        $finish;
    end

endmodule
